FILE: rtl/ghps_pkg.sv
`default_nettype none
package ghps_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TAP,
    ST_COEF,
    ST_H1,
    ST_H2,
    ST_H3,
    ST_AVG,
    ST_WGT,
    ST_MIX1,
    ST_MIX2
  } state_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PITCH = 2'd0,
    CFG_MIX   = 2'd1,
    CFG_CHAN  = 2'd2
  } cfg_idx_t;

  // Addend of each Horner step
  typedef enum logic [1:0] {
    ADD_C2,
    ADD_C1,
    ADD_Y1X2
  } horner_add_t;

  typedef struct packed {
    logic        tap_load;
    logic        coef;
    logic        horner;
    horner_add_t add_sel;
    logic        avg;
    logic        wgt;
    logic        adv;
    logic        stereo;
  } lane_ctl_t;

  localparam int RATIO_W = 18;
  localparam int GAIN_W  = 17;
  localparam int CHAN_W  = 2;
  localparam int CFG_W   = 18;
  localparam int FRAC_W  = 16;
  localparam logic [16:0] UNITY = 17'd65536;

endpackage
`default_nettype wire

FILE: rtl/ghps_lane.sv
`default_nettype none
module ghps_lane #(
  parameter int HISTORY_DEPTH = 4096,
  parameter int GRAIN_LENGTH  = 2048,
  parameter int SAMPLE_BITS   = 24,
  parameter int HEAD          = 0,
  localparam int AW  = $clog2(HISTORY_DEPTH),
  localparam int CW  = SAMPLE_BITS + 6,
  localparam int WPW = CW + 1
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire ghps_pkg::lane_ctl_t     ctl,
  input  wire [ghps_pkg::RATIO_W-1:0]  ratio,
  input  wire [AW-1:0]                 wi,
  input  wire signed [SAMPLE_BITS-1:0] tap_l,
  input  wire signed [SAMPLE_BITS-1:0] tap_r,
  output logic [AW-1:0]                base,
  output logic signed [WPW-1:0]        wprod
);

  localparam int GW = $clog2(GRAIN_LENGTH);
  localparam int PW = GW + ghps_pkg::FRAC_W;
  localparam int HN = GRAIN_LENGTH / 2 + 1;
  localparam int QW = $clog2(HN);
  localparam int MW = CW + 17;
  localparam logic [PW-1:0] INIT_PH = (HEAD != 0) ? (PW'(GRAIN_LENGTH) << 15) : '0;
  localparam logic [PW:0]   SPAN    = (PW + 1)'(GRAIN_LENGTH) << 16;

  // sin^2 window entry, Q16, Taylor series in Q30
  function automatic logic [16:0] hann_calc(input int unsigned qi);
    logic [63:0] x, x2, t, s, w;
    begin
      x  = (64'd3373259426 * 64'(qi)) / 64'(GRAIN_LENGTH);
      x2 = (x * x) >> 30;
      t  = x;
      s  = x;
      t  = ((t * x2) >> 30) / 64'd6;
      s  = s - t;
      t  = ((t * x2) >> 30) / 64'd20;
      s  = s + t;
      t  = ((t * x2) >> 30) / 64'd42;
      s  = s - t;
      t  = ((t * x2) >> 30) / 64'd72;
      s  = s + t;
      t  = ((t * x2) >> 30) / 64'd110;
      s  = s - t;
      w  = (s * s) >> 44;
      if (w > 64'd65536) begin
        w = 64'd65536;
      end
      return w[16:0];
    end
  endfunction

  logic [16:0] hann_tab [HN];
  for (genvar i = 0; i < HN; i++) begin : g_rom
    assign hann_tab[i] = hann_calc(i);
  end

  logic [PW-1:0]             phase_r;
  logic [PW:0]               ph_sum;
  logic [GW-1:0]             pint;
  logic [15:0]               fr;
  logic [GW:0]               q_full;
  logic [QW-1:0]             q;
  logic [16:0]               w_r;
  logic signed [CW-1:0]      y_r   [2][4];
  logic signed [CW-1:0]      c1_r  [2];
  logic signed [CW-1:0]      c2_r  [2];
  logic signed [CW-1:0]      y1x2_r[2];
  logic signed [CW-1:0]      acc_r [2];
  logic signed [CW-1:0]      smp_r;
  logic signed [WPW-1:0]     wp_r;
  logic signed [MW-1:0]      prod  [2];
  logic signed [CW-1:0]      addend[2];
  logic signed [CW-1:0]      hl, hr, smp_nxt;
  logic signed [CW+17:0]     wfull;

  assign pint = phase_r[PW-1:ghps_pkg::FRAC_W];
  assign fr   = phase_r[ghps_pkg::FRAC_W-1:0];
  assign base = wi - AW'(GRAIN_LENGTH) + AW'(pint);

  // window is symmetric: fold the phase to the first half
  always_comb begin
    if ({1'b0, pint} <= (GW + 1)'(GRAIN_LENGTH / 2)) begin
      q_full = {1'b0, pint};
    end else begin
      q_full = (GW + 1)'(GRAIN_LENGTH) - {1'b0, pint};
    end
    q = QW'(q_full);
  end

  always_ff @(posedge clk) begin
    w_r <= hann_tab[q];
  end

  assign ph_sum = {1'b0, phase_r} + (PW + 1)'(ratio);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= INIT_PH;
    end else if (ctl.adv) begin
      if (ph_sum >= SPAN) begin
        phase_r <= PW'(ph_sum - SPAN);
      end else begin
        phase_r <= PW'(ph_sum);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      prod[ch] = acc_r[ch] * $signed({1'b0, fr});
      case (ctl.add_sel)
        ghps_pkg::ADD_C2: addend[ch] = c2_r[ch];
        ghps_pkg::ADD_C1: addend[ch] = c1_r[ch];
        default:          addend[ch] = y1x2_r[ch];
      endcase
    end
    hl = acc_r[0] >>> 1;
    hr = acc_r[1] >>> 1;
    smp_nxt = ctl.stereo ? ((hl + hr) >>> 1) : hl;
    wfull = smp_r * $signed({1'b0, w_r});
  end

  always_ff @(posedge clk) begin
    if (ctl.tap_load) begin
      for (int k = 0; k < 3; k++) begin
        y_r[0][k] <= y_r[0][k+1];
        y_r[1][k] <= y_r[1][k+1];
      end
      y_r[0][3] <= CW'(tap_l);
      y_r[1][3] <= CW'(tap_r);
    end
    for (int ch = 0; ch < 2; ch++) begin
      if (ctl.coef) begin
        c1_r[ch]   <= y_r[ch][2] - y_r[ch][0];
        c2_r[ch]   <= CW'(2 * y_r[ch][0] - 5 * y_r[ch][1] + 4 * y_r[ch][2] - y_r[ch][3]);
        y1x2_r[ch] <= CW'(2 * y_r[ch][1]);
        acc_r[ch]  <= CW'((y_r[ch][3] - y_r[ch][0]) + 3 * (y_r[ch][1] - y_r[ch][2]));
      end else if (ctl.horner) begin
        acc_r[ch] <= CW'(prod[ch] >>> 16) + addend[ch];
      end
    end
    if (ctl.avg) begin
      smp_r <= smp_nxt;
    end
    if (ctl.wgt) begin
      wp_r <= WPW'(wfull >>> 16);
    end
  end

  assign wprod = wp_r;

endmodule
`default_nettype wire

FILE: rtl/two_head_granular_pitch_shifter_core.sv
// Two-head granular pitch shifter, one stereo sample per transaction.
// Input channel in_valid/in_ready carries in_left/in_right (signed Q1.23).
// Output channel out_valid/out_ready carries out_left/out_right.
// Config port: cfg_we with cfg_index/cfg_data writes pitch_ratio (0),
// mix_gain (1) or channel_count (2); write only while idle.
// Each sample goes into the left ring (and the right in stereo). Two lanes, one per read
// head, fetch four taps each from the rings (two read ports per ring),
// run a Hermite Horner evaluation on one multiplier per channel and weight
// the result with a Hann ROM; the merge stage sums the heads and mixes wet
// with dry, saturating to the sample width.
// The result is registered after the tap reads (4 per ring port), the
// coefficient step, the 3 Horner steps and the average, weight and mix
// steps; a new input is taken only while idle, once the result is loaded.
// Reset (synchronous, rst_n low) restores register defaults and starts a
// clearing pass over all HISTORY_DEPTH entries (4096 by default) that
// zeroes both rings; in_ready stays low until it ends.
// If the receiver stalls, the result waits in the output register; the next
// sample is still accepted and its result holds in the last mix step.
`default_nettype none
module two_head_granular_pitch_shifter_core #(
  parameter int HISTORY_DEPTH = 4096,
  parameter int GRAIN_LENGTH  = 2048,
  parameter int SAMPLE_BITS   = 24
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire signed [SAMPLE_BITS-1:0]     in_left,
  input  wire signed [SAMPLE_BITS-1:0]     in_right,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]    out_left,
  output logic signed [SAMPLE_BITS-1:0]    out_right,
  input  wire                              cfg_we,
  input  wire [ghps_pkg::CHAN_W-1:0]       cfg_index,
  input  wire [ghps_pkg::CFG_W-1:0]        cfg_data
);

  localparam int AW  = $clog2(HISTORY_DEPTH);
  localparam int CW  = SAMPLE_BITS + 6;
  localparam int WPW = CW + 1;
  localparam int MXW = WPW + 20;
  localparam logic signed [MXW-1:0] SAT_HI = MXW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [MXW-1:0] SAT_LO = -SAT_HI - 1;

  ghps_pkg::state_t state_r, state_nxt;
  ghps_pkg::lane_ctl_t ctl;

  logic [AW-1:0]                  clr_r;
  logic [AW-1:0]                  wi_r;
  logic [2:0]                     tap_r;
  logic signed [SAMPLE_BITS-1:0]  l_r, r_r;
  logic [ghps_pkg::RATIO_W-1:0]   ratio_r;
  logic [ghps_pkg::GAIN_W-1:0]    gain_r;
  logic [ghps_pkg::CHAN_W-1:0]    chan_r;
  logic                           stereo;
  logic                           accept;
  logic                           out_load;
  logic                           out_valid_r;
  logic signed [SAMPLE_BITS-1:0]  out_l_r, out_r_r;

  // history rings, two read ports each (one per head)
  logic signed [SAMPLE_BITS-1:0]  mem_l [HISTORY_DEPTH];
  logic signed [SAMPLE_BITS-1:0]  mem_r [HISTORY_DEPTH];
  logic signed [SAMPLE_BITS-1:0]  rdl_r [2];
  logic signed [SAMPLE_BITS-1:0]  rdr_r [2];
  logic [AW-1:0]                  base  [2];
  logic [AW-1:0]                  raddr [2];
  logic signed [WPW-1:0]          wprod [2];

  logic [16:0]                    g, dryg;
  logic signed [WPW:0]            wet;
  logic signed [SAMPLE_BITS+17:0] mul_l, mul_r;
  logic signed [WPW+18:0]         mul_w;
  logic signed [MXW-1:0]          pl_r, pr_r, pw_r, sum_l, sum_r, sh_l, sh_r;
  logic signed [SAMPLE_BITS-1:0]  sat_l, sat_r;

  assign stereo   = (chan_r >= 2'd2);
  assign in_ready = (state_r == ghps_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == ghps_pkg::ST_MIX2) && (!out_valid_r || out_ready);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= 18'd65536;
      gain_r  <= 17'd65536;
      chan_r  <= 2'd2;
    end else if (cfg_we) begin
      unique case (ghps_pkg::cfg_idx_t'(cfg_index))
        ghps_pkg::CFG_PITCH: ratio_r <= cfg_data;
        ghps_pkg::CFG_MIX:   gain_r  <= cfg_data[ghps_pkg::GAIN_W-1:0];
        ghps_pkg::CFG_CHAN:  chan_r  <= cfg_data[ghps_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ghps_pkg::ST_CLEAR: if (clr_r == AW'(HISTORY_DEPTH - 1)) state_nxt = ghps_pkg::ST_IDLE;
      ghps_pkg::ST_IDLE:  if (accept) state_nxt = ghps_pkg::ST_TAP;
      ghps_pkg::ST_TAP:   if (tap_r == 3'd4) state_nxt = ghps_pkg::ST_COEF;
      ghps_pkg::ST_COEF:  state_nxt = ghps_pkg::ST_H1;
      ghps_pkg::ST_H1:    state_nxt = ghps_pkg::ST_H2;
      ghps_pkg::ST_H2:    state_nxt = ghps_pkg::ST_H3;
      ghps_pkg::ST_H3:    state_nxt = ghps_pkg::ST_AVG;
      ghps_pkg::ST_AVG:   state_nxt = ghps_pkg::ST_WGT;
      ghps_pkg::ST_WGT:   state_nxt = ghps_pkg::ST_MIX1;
      ghps_pkg::ST_MIX1:  state_nxt = ghps_pkg::ST_MIX2;
      ghps_pkg::ST_MIX2:  if (out_load) state_nxt = ghps_pkg::ST_IDLE;
      default:            state_nxt = ghps_pkg::ST_CLEAR;
    endcase
  end

  // lane controls
  always_comb begin
    ctl          = '0;
    ctl.stereo   = stereo;
    ctl.add_sel  = ghps_pkg::ADD_C2;
    unique case (state_r)
      ghps_pkg::ST_TAP:  ctl.tap_load = (tap_r != 3'd0);
      ghps_pkg::ST_COEF: ctl.coef = 1'b1;
      ghps_pkg::ST_H1: begin
        ctl.horner  = 1'b1;
        ctl.add_sel = ghps_pkg::ADD_C2;
      end
      ghps_pkg::ST_H2: begin
        ctl.horner  = 1'b1;
        ctl.add_sel = ghps_pkg::ADD_C1;
      end
      ghps_pkg::ST_H3: begin
        ctl.horner  = 1'b1;
        ctl.add_sel = ghps_pkg::ADD_Y1X2;
      end
      ghps_pkg::ST_AVG:  ctl.avg = 1'b1;
      ghps_pkg::ST_WGT:  ctl.wgt = 1'b1;
      ghps_pkg::ST_MIX1: ctl.adv = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ghps_pkg::ST_CLEAR;
      clr_r       <= '0;
      wi_r        <= '0;
      tap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ghps_pkg::ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (accept) begin
        tap_r <= '0;
      end else if (state_r == ghps_pkg::ST_TAP) begin
        tap_r <= tap_r + 1'b1;
      end
      if (out_load) begin
        wi_r        <= wi_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      l_r <= in_left;
      r_r <= in_right;
    end
  end

  // ring write: clearing pass or the new sample
  always_ff @(posedge clk) begin
    if (state_r == ghps_pkg::ST_CLEAR) begin
      mem_l[clr_r] <= '0;
      mem_r[clr_r] <= '0;
    end else if (accept) begin
      mem_l[wi_r] <= in_left;
      if (stereo) begin
        mem_r[wi_r] <= in_right;
      end
    end
  end

  // tap k of a head sits at base + k - 1
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      raddr[j] = base[j] + AW'(tap_r[1:0]) - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 2; j++) begin
      rdl_r[j] <= mem_l[raddr[j]];
      rdr_r[j] <= mem_r[raddr[j]];
    end
  end

  for (genvar j = 0; j < 2; j++) begin : g_lane
    ghps_lane #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .GRAIN_LENGTH  (GRAIN_LENGTH),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .HEAD          (j)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .ratio (ratio_r),
      .wi    (wi_r),
      .tap_l (rdl_r[j]),
      .tap_r (rdr_r[j]),
      .base  (base[j]),
      .wprod (wprod[j])
    );
  end

  // merge: wet sum and dry/wet mix
  assign g    = (gain_r > ghps_pkg::UNITY) ? ghps_pkg::UNITY : gain_r;
  assign dryg = ghps_pkg::UNITY - g;
  assign wet  = (WPW + 1)'(wprod[0]) + (WPW + 1)'(wprod[1]);

  // full-width products
  assign mul_l = l_r * $signed({1'b0, dryg});
  assign mul_r = r_r * $signed({1'b0, dryg});
  assign mul_w = wet * $signed({1'b0, g});

  always_ff @(posedge clk) begin
    if (state_r == ghps_pkg::ST_MIX1) begin
      pl_r <= MXW'(mul_l);
      pr_r <= MXW'(mul_r);
      pw_r <= MXW'(mul_w);
    end
  end

  always_comb begin
    sum_l = pl_r + pw_r;
    sum_r = pr_r + pw_r;
    sh_l  = sum_l >>> 16;
    sh_r  = sum_r >>> 16;
    if (sh_l > SAT_HI) begin
      sat_l = SAMPLE_BITS'(SAT_HI);
    end else if (sh_l < SAT_LO) begin
      sat_l = SAMPLE_BITS'(SAT_LO);
    end else begin
      sat_l = SAMPLE_BITS'(sh_l);
    end
    if (sh_r > SAT_HI) begin
      sat_r = SAMPLE_BITS'(SAT_HI);
    end else if (sh_r < SAT_LO) begin
      sat_r = SAMPLE_BITS'(SAT_LO);
    end else begin
      sat_r = SAMPLE_BITS'(sh_r);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_l_r <= sat_l;
      out_r_r <= stereo ? sat_r : sat_l;
    end
  end

  assign out_valid = out_valid_r;
  assign out_left  = out_l_r;
  assign out_right = out_r_r;

endmodule
`default_nettype wire

FILE: rtl/ghps_checker.sv
`default_nettype none
module ghps_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire signed [SAMPLE_BITS-1:0] out_left,
  input wire signed [SAMPLE_BITS-1:0] out_right
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right))
    else $error("result changed while stalled");

  // one sample in flight at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // a result taken while idle leaves nothing behind it
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && in_ready |=> !out_valid)
    else $error("result repeated");

  // reset starts the clearing pass with nothing pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("busy state after reset");

endmodule

bind two_head_granular_pitch_shifter_core ghps_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_ghps_checker (.*);
`default_nettype wire
